// File: rtl/ray_cylinder_intersect_top_macros.svh
// assertion macros shared by the checker
// each takes a label, an antecedent, a consequent and a message
// clk and arst_n are taken from the scope of the use
`ifndef RAY_CYLINDER_INTERSECT_TOP_MACROS_SVH
`define RAY_CYLINDER_INTERSECT_TOP_MACROS_SVH

// same-cycle implication
`define RCI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rci_pkg.sv
package rci_pkg;

	localparam int W   = 32;
	localparam int F   = 16;
	localparam int W2  = 2 * W;
	localparam int QW  = W + F;
	localparam int RW  = QW / 2;

	localparam int DIV_STEPS = 4;
	localparam int DIV_LAT   = QW / DIV_STEPS + 1;
	localparam int SQ_STEPS  = 4;
	localparam int SQ_LAT    = RW / SQ_STEPS + 1;

	localparam int CFG_IDX_W = 3;

	typedef logic signed [W-1:0] word_t;

	localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};
	localparam word_t ONE  = W'(1) << F;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_AXIS_X   = 3'd3,
		REG_AXIS_Y   = 3'd4,
		REG_AXIS_Z   = 3'd5,
		REG_DIAMETER = 3'd6,
		REG_HEIGHT   = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic  ok;
		logic  first;
		word_t m;
	} pick_t;

	function automatic word_t qadd(word_t a, word_t b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? WMIN : WMAX;
		return s[W-1:0];
	endfunction

	function automatic word_t qsub(word_t a, word_t b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? WMIN : WMAX;
		return s[W-1:0];
	endfunction

	function automatic word_t qneg(word_t a);
		return (a == WMIN) ? WMAX : -a;
	endfunction

	// exact product, floored to the fraction, saturated
	function automatic word_t qmul(word_t a, word_t b);
		logic signed [W2-1:0] p;
		logic signed [W2-1:0] fl;
		p  = W2'(a) * W2'(b);
		fl = p >>> F;
		if (fl[W2-1:W-1] != {(W2-W+1){fl[W2-1]}})
			return fl[W2-1] ? WMIN : WMAX;
		return fl[W-1:0];
	endfunction

	// nearer non-negative candidate; equal candidates give none
	function automatic pick_t pick(word_t m0, word_t m1);
		pick_t r;
		r = '0;
		priority if (!m0[W-1] && (m0 < m1 || m1[W-1])) begin
			r.ok    = 1'b1;
			r.first = 1'b1;
			r.m     = m0;
		end else if (!m1[W-1] && (m1 < m0 || m0[W-1])) begin
			r.ok    = 1'b1;
			r.first = 1'b0;
			r.m     = m1;
		end else begin
			r.ok    = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: rtl/ray_cylinder_intersect_top.sv
// ray against finite cylinder, Q16.16 fixed point
// input channel in_valid/in_ready carries one ray word: origin org_* and unit
// direction dir_*. output channel out_valid/out_ready carries one result word
// per ray: wall hit flag and point, lid hit flag, lid choice and point.
// cylinder geometry sits in eight registers written over the cfg_* channel
// (index 0..7: center x/y/z, axis x/y/z, diameter, height); cfg_ready is
// always high. write them only while no ray is in flight.
// pipeline depth: two 13-stage dividers and a 7-stage square root in series
// with the multiply and add stages around them.
// throughput: one ray per cycle while the skid register is empty; no stall
// cycles of its own.
// when the receiver stalls, the result parks in the output register and one
// more result in a skid register; only then does in_ready drop and the whole
// pipeline freeze, so nothing is lost or repeated.
// reset: pipeline and output valid bits clear, registers take their reset
// geometry (center 0, axis +y, diameter 1.0, height 1.0).
module ray_cylinder_intersect_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rci_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rci_pkg::W-1:0]               cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rci_pkg::word_t                      org_x,
	input  rci_pkg::word_t                      org_y,
	input  rci_pkg::word_t                      org_z,
	input  rci_pkg::word_t                      dir_x,
	input  rci_pkg::word_t                      dir_y,
	input  rci_pkg::word_t                      dir_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                wall_hit,
	output rci_pkg::word_t                      wall_x,
	output rci_pkg::word_t                      wall_y,
	output rci_pkg::word_t                      wall_z,
	output logic                                lid_hit,
	output logic                                lid_top,
	output rci_pkg::word_t                      lid_x,
	output rci_pkg::word_t                      lid_y,
	output rci_pkg::word_t                      lid_z
);
	import rci_pkg::*;

	// everything an item carries down the pipe; unused fields trim away
	typedef struct packed {
		word_t ox, oy, oz, dx, dy, dz, px, py, pz;
		word_t aax, aay, aaz, ddx, ddy, ddz, adx, ady, adz, r2;
		word_t aa, dd, axd, ppx, ppy, ppz, pdx, pdy, pdz, apx, apy, apz;
		word_t pp, pd, axp, t1, t2, t3, ln0, ln1;
		word_t a, a2, a4, b, cw, lm;
		logic  lok, ltop;
		word_t bb, ac, disc, nb;
		logic  wpre;
		word_t n0, n1, wm;
		logic  wok;
		word_t wsx, wsy, wsz, lsx, lsy, lsz;
		word_t wvx, wvy, wvz, wptx, wpty, wptz;
		word_t lvx, lvy, lvz, lptx, lpty, lptz;
		word_t wax, way, waz, lax, lay, laz, lqx, lqy, lqz;
		word_t axial, aq, lqq, aqaq;
		logic  whit;
	} item_t;

	typedef struct packed {
		logic  wall_hit;
		word_t wall_x, wall_y, wall_z;
		logic  lid_hit;
		logic  lid_top;
		word_t lid_x, lid_y, lid_z;
	} res_t;

	// ---------------- configuration registers ----------------
	word_t        ctr_x_q, ctr_y_q, ctr_z_q;
	word_t        ax_x_q, ax_y_q, ax_z_q;
	logic [W-2:0] diam_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q  <= '0;
			ctr_y_q  <= '0;
			ctr_z_q  <= '0;
			ax_x_q   <= '0;
			ax_y_q   <= ONE;
			ax_z_q   <= '0;
			diam_q   <= ONE[W-2:0];
			height_q <= ONE[W-2:0];
		end else if (cfg_valid) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_CENTER_X: ctr_x_q  <= cfg_data;
				REG_CENTER_Y: ctr_y_q  <= cfg_data;
				REG_CENTER_Z: ctr_z_q  <= cfg_data;
				REG_AXIS_X:   ax_x_q   <= cfg_data;
				REG_AXIS_Y:   ax_y_q   <= cfg_data;
				REG_AXIS_Z:   ax_z_q   <= cfg_data;
				REG_DIAMETER: diam_q   <= cfg_data[W-2:0];
				REG_HEIGHT:   height_q <= cfg_data[W-2:0];
				default:      ;
			endcase
		end
	end

	// radius and half height, floored halves
	word_t rad, hh;
	assign rad = {2'b00, diam_q[W-2:1]};
	assign hh  = {2'b00, height_q[W-2:1]};

	// global advance: the pipe moves unless the skid register is occupied
	logic en;
	logic skid_v_q;
	assign en       = !skid_v_q;
	assign in_ready = en;

	// ---------------- stage 1: offset and first products ----------------
	item_t item_n1, item_s1;
	logic  v_s1;

	always_comb begin
		item_n1     = '0;
		item_n1.ox  = org_x;
		item_n1.oy  = org_y;
		item_n1.oz  = org_z;
		item_n1.dx  = dir_x;
		item_n1.dy  = dir_y;
		item_n1.dz  = dir_z;
		item_n1.px  = qsub(org_x, ctr_x_q);
		item_n1.py  = qsub(org_y, ctr_y_q);
		item_n1.pz  = qsub(org_z, ctr_z_q);
		item_n1.aax = qmul(ax_x_q, ax_x_q);
		item_n1.aay = qmul(ax_y_q, ax_y_q);
		item_n1.aaz = qmul(ax_z_q, ax_z_q);
		item_n1.ddx = qmul(dir_x, dir_x);
		item_n1.ddy = qmul(dir_y, dir_y);
		item_n1.ddz = qmul(dir_z, dir_z);
		item_n1.adx = qmul(ax_x_q, dir_x);
		item_n1.ady = qmul(ax_y_q, dir_y);
		item_n1.adz = qmul(ax_z_q, dir_z);
		item_n1.r2  = qmul(rad, rad);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s1 <= item_n1;
	end

	// ---------------- stage 2: dot sums, products with offset ----------------
	item_t item_n2, item_s2;
	logic  v_s2;

	always_comb begin
		item_n2     = item_s1;
		item_n2.aa  = qadd(qadd(item_s1.aax, item_s1.aay), item_s1.aaz);
		item_n2.dd  = qadd(qadd(item_s1.ddx, item_s1.ddy), item_s1.ddz);
		item_n2.axd = qadd(qadd(item_s1.adx, item_s1.ady), item_s1.adz);
		item_n2.ppx = qmul(item_s1.px, item_s1.px);
		item_n2.ppy = qmul(item_s1.py, item_s1.py);
		item_n2.ppz = qmul(item_s1.pz, item_s1.pz);
		item_n2.pdx = qmul(item_s1.px, item_s1.dx);
		item_n2.pdy = qmul(item_s1.py, item_s1.dy);
		item_n2.pdz = qmul(item_s1.pz, item_s1.dz);
		item_n2.apx = qmul(ax_x_q, item_s1.px);
		item_n2.apy = qmul(ax_y_q, item_s1.py);
		item_n2.apz = qmul(ax_z_q, item_s1.pz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s2 <= item_n2;
	end

	// ---------------- stage 3: offset dots, axial term of direction ----------------
	item_t item_n3, item_s3;
	logic  v_s3;

	always_comb begin
		item_n3     = item_s2;
		item_n3.pp  = qadd(qadd(item_s2.ppx, item_s2.ppy), item_s2.ppz);
		item_n3.pd  = qadd(qadd(item_s2.pdx, item_s2.pdy), item_s2.pdz);
		item_n3.axp = qadd(qadd(item_s2.apx, item_s2.apy), item_s2.apz);
		item_n3.t1  = qmul(item_s2.axd, item_s2.axd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s3 <= item_n3;
	end

	// ---------------- stage 4: remaining axial terms, lid numerators ----------------
	item_t item_n4, item_s4;
	logic  v_s4;

	always_comb begin
		item_n4     = item_s3;
		item_n4.t2  = qmul(item_s3.axp, item_s3.axd);
		item_n4.t3  = qmul(item_s3.axp, item_s3.axp);
		item_n4.ln0 = qsub(hh, item_s3.axp);
		item_n4.ln1 = qsub(-hh, item_s3.axp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s4 <= item_n4;
	end

	// ---------------- first divider bank: axis projection and lid planes ----------------
	item_t item_s5;
	logic  v_s5;
	word_t q1, q2, q3, qm0, qm1;

	rci_delay #(.WIDTH($bits(item_t)), .DEPTH(DIV_LAT)) u_dly_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (en),
		.src_valid (v_s4),
		.src_data  (item_s4),
		.dst_valid (v_s5),
		.dst_data  (item_s5)
	);

	rci_div u_div_t1 (.clk(clk), .advance(en), .dividend(item_s4.t1),
		.divisor(item_s4.aa), .quotient(q1));
	rci_div u_div_t2 (.clk(clk), .advance(en), .dividend(item_s4.t2),
		.divisor(item_s4.aa), .quotient(q2));
	rci_div u_div_t3 (.clk(clk), .advance(en), .dividend(item_s4.t3),
		.divisor(item_s4.aa), .quotient(q3));
	rci_div u_div_m0 (.clk(clk), .advance(en), .dividend(item_s4.ln0),
		.divisor(item_s4.axd), .quotient(qm0));
	rci_div u_div_m1 (.clk(clk), .advance(en), .dividend(item_s4.ln1),
		.divisor(item_s4.axd), .quotient(qm1));

	// ---------------- stage 6: quadratic coefficients, lid plane choice ----------------
	item_t item_n6, item_s6;
	logic  v_s6;
	pick_t lid_pk;
	word_t pdw;

	always_comb begin
		item_n6      = item_s5;
		pdw          = qsub(item_s5.pd, q2);
		item_n6.a    = qsub(item_s5.dd, q1);
		item_n6.cw   = qsub(qsub(item_s5.pp, q3), item_s5.r2);
		item_n6.b    = qadd(pdw, pdw);
		item_n6.a2   = qadd(item_n6.a, item_n6.a);
		item_n6.a4   = qadd(item_n6.a2, item_n6.a2);
		lid_pk       = pick(qm0, qm1);
		item_n6.lok  = (item_s5.axd != '0) && lid_pk.ok;
		item_n6.ltop = lid_pk.first;
		item_n6.lm   = lid_pk.m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s6 <= item_n6;
	end

	// ---------------- stage 7: discriminant products ----------------
	item_t item_n7, item_s7;
	logic  v_s7;

	always_comb begin
		item_n7    = item_s6;
		item_n7.bb = qmul(item_s6.b, item_s6.b);
		item_n7.ac = qmul(item_s6.a4, item_s6.cw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s7 <= item_n7;
	end

	// ---------------- stage 8: discriminant, wall preconditions ----------------
	item_t item_n8, item_s8;
	logic  v_s8;

	always_comb begin
		item_n8      = item_s7;
		item_n8.disc = qsub(item_s7.bb, item_s7.ac);
		item_n8.nb   = qneg(item_s7.b);
		item_n8.wpre = (item_s7.aa != '0) && (item_s7.a != '0) && !item_n8.disc[W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s8 <= item_n8;
	end

	// ---------------- square root of the discriminant ----------------
	item_t item_s9;
	logic  v_s9;
	word_t sq_in, sq_root;

	// a negative discriminant is a miss anyway, feed zero
	assign sq_in = item_s8.disc[W-1] ? '0 : item_s8.disc;

	rci_delay #(.WIDTH($bits(item_t)), .DEPTH(SQ_LAT)) u_dly_sq (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (en),
		.src_valid (v_s8),
		.src_data  (item_s8),
		.dst_valid (v_s9),
		.dst_data  (item_s9)
	);

	rci_sqrt u_sqrt (.clk(clk), .advance(en), .radicand(sq_in), .root(sq_root));

	// ---------------- stage 10: root numerators ----------------
	item_t item_n10, item_s10;
	logic  v_s10;

	always_comb begin
		item_n10    = item_s9;
		item_n10.n0 = qsub(item_s9.nb, sq_root);
		item_n10.n1 = qadd(item_s9.nb, sq_root);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s10 <= item_n10;
	end

	// ---------------- second divider bank: wall roots ----------------
	item_t item_s11;
	logic  v_s11;
	word_t r0, r1;

	rci_delay #(.WIDTH($bits(item_t)), .DEPTH(DIV_LAT)) u_dly_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (en),
		.src_valid (v_s10),
		.src_data  (item_s10),
		.dst_valid (v_s11),
		.dst_data  (item_s11)
	);

	rci_div u_div_r0 (.clk(clk), .advance(en), .dividend(item_s10.n0),
		.divisor(item_s10.a2), .quotient(r0));
	rci_div u_div_r1 (.clk(clk), .advance(en), .dividend(item_s10.n1),
		.divisor(item_s10.a2), .quotient(r1));

	// ---------------- stage 12: wall root choice ----------------
	item_t item_n12, item_s12;
	logic  v_s12;
	pick_t wall_pk;
	logic  opp;

	always_comb begin
		item_n12     = item_s11;
		opp          = (r0[W-1] && !r1[W-1] && r1 != '0)
			|| (r1[W-1] && !r0[W-1] && r0 != '0);
		wall_pk      = pick(r0, r1);
		item_n12.wok = item_s11.wpre && !opp && wall_pk.ok;
		item_n12.wm  = wall_pk.m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s12 <= 1'b0;
		else if (en)
			v_s12 <= v_s11;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s12 <= item_n12;
	end

	// ---------------- stage 13: steps along the ray ----------------
	item_t item_n13, item_s13;
	logic  v_s13;

	always_comb begin
		item_n13     = item_s12;
		item_n13.wsx = qmul(item_s12.dx, item_s12.wm);
		item_n13.wsy = qmul(item_s12.dy, item_s12.wm);
		item_n13.wsz = qmul(item_s12.dz, item_s12.wm);
		item_n13.lsx = qmul(item_s12.dx, item_s12.lm);
		item_n13.lsy = qmul(item_s12.dy, item_s12.lm);
		item_n13.lsz = qmul(item_s12.dz, item_s12.lm);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s13 <= 1'b0;
		else if (en)
			v_s13 <= v_s12;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s13 <= item_n13;
	end

	// ---------------- stage 14: hit points, local and world ----------------
	item_t item_n14, item_s14;
	logic  v_s14;

	always_comb begin
		item_n14      = item_s13;
		item_n14.wvx  = qadd(item_s13.px, item_s13.wsx);
		item_n14.wvy  = qadd(item_s13.py, item_s13.wsy);
		item_n14.wvz  = qadd(item_s13.pz, item_s13.wsz);
		item_n14.wptx = qadd(item_s13.ox, item_s13.wsx);
		item_n14.wpty = qadd(item_s13.oy, item_s13.wsy);
		item_n14.wptz = qadd(item_s13.oz, item_s13.wsz);
		item_n14.lvx  = qadd(item_s13.px, item_s13.lsx);
		item_n14.lvy  = qadd(item_s13.py, item_s13.lsy);
		item_n14.lvz  = qadd(item_s13.pz, item_s13.lsz);
		item_n14.lptx = qadd(item_s13.lsx, item_s13.ox);
		item_n14.lpty = qadd(item_s13.lsy, item_s13.oy);
		item_n14.lptz = qadd(item_s13.lsz, item_s13.oz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s14 <= 1'b0;
		else if (en)
			v_s14 <= v_s13;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s14 <= item_n14;
	end

	// ---------------- stage 15: axial and radial products ----------------
	item_t item_n15, item_s15;
	logic  v_s15;

	always_comb begin
		item_n15     = item_s14;
		item_n15.wax = qmul(ax_x_q, item_s14.wvx);
		item_n15.way = qmul(ax_y_q, item_s14.wvy);
		item_n15.waz = qmul(ax_z_q, item_s14.wvz);
		item_n15.lax = qmul(ax_x_q, item_s14.lvx);
		item_n15.lay = qmul(ax_y_q, item_s14.lvy);
		item_n15.laz = qmul(ax_z_q, item_s14.lvz);
		item_n15.lqx = qmul(item_s14.lvx, item_s14.lvx);
		item_n15.lqy = qmul(item_s14.lvy, item_s14.lvy);
		item_n15.lqz = qmul(item_s14.lvz, item_s14.lvz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s15 <= 1'b0;
		else if (en)
			v_s15 <= v_s14;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s15 <= item_n15;
	end

	// ---------------- stage 16: dot sums ----------------
	item_t item_n16, item_s16;
	logic  v_s16;

	always_comb begin
		item_n16       = item_s15;
		item_n16.axial = qadd(qadd(item_s15.wax, item_s15.way), item_s15.waz);
		item_n16.aq    = qadd(qadd(item_s15.lax, item_s15.lay), item_s15.laz);
		item_n16.lqq   = qadd(qadd(item_s15.lqx, item_s15.lqy), item_s15.lqz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s16 <= 1'b0;
		else if (en)
			v_s16 <= v_s15;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s16 <= item_n16;
	end

	// ---------------- stage 17: wall height check, axial square ----------------
	item_t item_n17, item_s17;
	logic  v_s17;
	word_t absax;

	always_comb begin
		item_n17      = item_s16;
		absax         = item_s16.axial[W-1] ? qneg(item_s16.axial) : item_s16.axial;
		item_n17.whit = item_s16.wok && (absax <= hh);
		item_n17.aqaq = qmul(item_s16.aq, item_s16.aq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s17 <= 1'b0;
		else if (en)
			v_s17 <= v_s16;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s17 <= item_n17;
	end

	// ---------------- lid radius check, result word ----------------
	res_t fin;
	logic lhit;

	always_comb begin
		lhit         = item_s17.lok
			&& (qsub(item_s17.lqq, item_s17.aqaq) < item_s17.r2);
		fin.wall_hit = item_s17.whit;
		fin.wall_x   = item_s17.whit ? item_s17.wptx : '0;
		fin.wall_y   = item_s17.whit ? item_s17.wpty : '0;
		fin.wall_z   = item_s17.whit ? item_s17.wptz : '0;
		fin.lid_hit  = lhit;
		fin.lid_top  = lhit && item_s17.ltop;
		fin.lid_x    = lhit ? item_s17.lptx : '0;
		fin.lid_y    = lhit ? item_s17.lpty : '0;
		fin.lid_z    = lhit ? item_s17.lptz : '0;
	end

	// ---------------- output register and skid ----------------
	res_t out_q, skid_q;
	logic out_v_q;
	logic out_free;

	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			// skid drains first, pipe is frozen meanwhile
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= v_s17;
			end
		end else if (v_s17 && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q)
				out_q <= skid_q;
			else
				out_q <= fin;
		end else if (en) begin
			skid_q <= fin;
		end
	end

	assign out_valid = out_v_q;
	assign wall_hit  = out_q.wall_hit;
	assign wall_x    = out_q.wall_x;
	assign wall_y    = out_q.wall_y;
	assign wall_z    = out_q.wall_z;
	assign lid_hit   = out_q.lid_hit;
	assign lid_top   = out_q.lid_top;
	assign lid_x     = out_q.lid_x;
	assign lid_y     = out_q.lid_y;
	assign lid_z     = out_q.lid_z;

endmodule

// File: rtl/rci_delay.sv
module rci_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             src_valid,
	input  logic [WIDTH-1:0] src_data,
	output logic             dst_valid,
	output logic [WIDTH-1:0] dst_data
);

	logic             vld_s [DEPTH];
	logic [WIDTH-1:0] dat_s [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_tap
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (advance)
					vld_s[k] <= src_valid;
			end
			always_ff @(posedge clk) begin
				if (advance)
					dat_s[k] <= src_data;
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (advance)
					vld_s[k] <= vld_s[k-1];
			end
			always_ff @(posedge clk) begin
				if (advance)
					dat_s[k] <= dat_s[k-1];
			end
		end
	end

	assign dst_valid = vld_s[DEPTH-1];
	assign dst_data  = dat_s[DEPTH-1];

endmodule

// File: rtl/rci_div.sv
module rci_div (
	input  logic           clk,
	input  logic           advance,
	input  rci_pkg::word_t dividend,
	input  rci_pkg::word_t divisor,
	output rci_pkg::word_t quotient
);
	import rci_pkg::*;

	typedef struct packed {
		logic [W-1:0]  rem;
		logic [QW-1:0] num;
		logic [QW-1:0] q;
		logic [W-1:0]  d;
		logic          neg;
	} div_st_t;

	// restoring division, DIV_STEPS quotient bits per stage
	function automatic div_st_t div_step(div_st_t s);
		div_st_t    r;
		logic [W:0] sh;
		r = s;
		for (int i = 0; i < DIV_STEPS; i++) begin
			sh    = {r.rem, r.num[QW-1]};
			r.num = {r.num[QW-2:0], 1'b0};
			if (sh >= {1'b0, r.d}) begin
				r.rem = W'(sh - {1'b0, r.d});
				r.q   = {r.q[QW-2:0], 1'b1};
			end else begin
				r.rem = sh[W-1:0];
				r.q   = {r.q[QW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	div_st_t div_s [DIV_LAT];
	div_st_t head;
	div_st_t tail;

	always_comb begin
		head.neg = dividend[W-1] ^ divisor[W-1];
		head.num = {(dividend[W-1] ? (~dividend + W'(1)) : dividend), {F{1'b0}}};
		head.d   = divisor[W-1] ? (~divisor + W'(1)) : divisor;
		head.rem = '0;
		head.q   = '0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			div_s[0] <= head;
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (advance)
				div_s[k] <= div_step(div_s[k-1]);
		end
	end

	// saturate the magnitude back into a signed word
	always_comb begin
		tail = div_s[DIV_LAT-1];
		if (!tail.neg) begin
			if (tail.q[QW-1:W-1] != '0)
				quotient = WMAX;
			else
				quotient = tail.q[W-1:0];
		end else begin
			if (tail.q[QW-1:W] != '0 || (tail.q[W-1] && tail.q[W-2:0] != '0))
				quotient = WMIN;
			else
				quotient = -tail.q[W-1:0];
		end
	end

endmodule

// File: rtl/rci_sqrt.sv
module rci_sqrt (
	input  logic           clk,
	input  logic           advance,
	input  rci_pkg::word_t radicand,
	output rci_pkg::word_t root
);
	import rci_pkg::*;

	typedef struct packed {
		logic [RW+1:0] rem;
		logic [QW-1:0] t;
		logic [RW-1:0] r;
	} sq_st_t;

	// digit-by-digit square root, two radicand bits per iteration
	function automatic sq_st_t sq_step(sq_st_t s);
		sq_st_t        o;
		logic [RW+3:0] sh;
		logic [RW+3:0] trial;
		o = s;
		for (int i = 0; i < SQ_STEPS; i++) begin
			sh    = {o.rem, o.t[QW-1:QW-2]};
			o.t   = {o.t[QW-3:0], 2'b00};
			trial = {2'b00, o.r, 2'b01};
			if (sh >= trial) begin
				o.rem = (RW+2)'(sh - trial);
				o.r   = {o.r[RW-2:0], 1'b1};
			end else begin
				o.rem = sh[RW+1:0];
				o.r   = {o.r[RW-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	sq_st_t sq_s [SQ_LAT];
	sq_st_t head;

	always_comb begin
		head.rem = '0;
		head.r   = '0;
		head.t   = {radicand, {F{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (advance)
			sq_s[0] <= head;
	end

	for (genvar k = 1; k < SQ_LAT; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (advance)
				sq_s[k] <= sq_step(sq_s[k-1]);
		end
	end

	assign root = W'(sq_s[SQ_LAT-1].r);

endmodule

// File: rtl/rci_checker.sv
`include "ray_cylinder_intersect_top_macros.svh"

module rci_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input logic           wall_hit,
	input rci_pkg::word_t wall_x,
	input rci_pkg::word_t wall_y,
	input rci_pkg::word_t wall_z,
	input logic           lid_hit,
	input logic           lid_top
);

	// a stalled result word holds
	`RCI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(wall_x) && $stable(wall_y) && $stable(wall_z) && $stable(wall_hit), "stalled result word changed")

	// wall point is zero on a wall miss
	`RCI_ASSERT_IMP(a_wall_zero, out_valid && !wall_hit, wall_x == '0 && wall_y == '0 && wall_z == '0, "wall point not zero on miss")

	// lid choice only reported with a lid hit
	`RCI_ASSERT_IMP(a_lid_top, out_valid && lid_top, lid_hit, "lid choice without lid hit")

	// input back-pressure only follows an output stall
	`RCI_ASSERT_IMP(a_ready_drop, $fell(in_ready), $past(out_valid && !out_ready), "in_ready dropped without output stall")

endmodule

bind ray_cylinder_intersect_top rci_checker u_rci_checker (.*);

// File: bench/ray_cylinder_intersect_top_test.sv
`timescale 1ns / 100ps

module ray_cylinder_intersect_top_test;
	import rci_pkg::*;

	localparam int LATENCY   = 47;
	localparam int CYCLE_CAP = 400000;
	localparam int N_RANDOM  = 730;

	// one ray word
	typedef struct {
		word_t ox, oy, oz, dx, dy, dz;
	} ray_t;

	// one result word
	typedef struct {
		logic  wh;
		word_t wx, wy, wz;
		logic  lh, lt;
		word_t lx, ly, lz;
	} hit_t;

	// directed row: ray plus optional typed-in result
	typedef struct {
		ray_t r;
		bit   fixed;
		hit_t h;
	} row_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [W-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	word_t org_x, org_y, org_z, dir_x, dir_y, dir_z;
	logic wall_hit, lid_hit, lid_top;
	word_t wall_x, wall_y, wall_z, lid_x, lid_y, lid_z;

	ray_cylinder_intersect_top uut (.*);

	// cylinder geometry as the predictor sees it
	word_t geo_c[3], geo_a[3];
	logic [W-2:0] geo_dia, geo_hgt;

	hit_t expected_hits[$];
	int   mismatches;
	int   cycles;
	bit   no_idle;
	bit   hold_off;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ---------------- predictor arithmetic, wide signed ----------------
	localparam longint VMX = 64'sd2147483647;
	localparam longint VMN = -64'sd2147483648;

	function automatic longint clampw(longint v);
		return v > VMX ? VMX : (v < VMN ? VMN : v);
	endfunction

	function automatic longint sadd(longint a, longint b);
		return clampw(a + b);
	endfunction

	function automatic longint ssub(longint a, longint b);
		return clampw(a - b);
	endfunction

	function automatic longint sneg(longint a);
		return a == VMN ? VMX : -a;
	endfunction

	function automatic longint smul(longint a, longint b);
		longint p;
		p = a * b;      // fits in 64 bits for 32-bit operands
		return clampw(p >>> F);
	endfunction

	// shifted numerator truncated toward zero
	function automatic longint sdiv(longint a, longint b);
		logic signed [95:0] n, q;
		n = 96'(a) <<< F;
		q = n / 96'(b);
		if (q > 96'(VMX)) return VMX;
		if (q < 96'(VMN)) return VMN;
		return longint'(q);
	endfunction

	function automatic longint ssqrt(longint v);
		logic [63:0] t, q, c;
		t = 64'(v) << F;
		q = 0;
		for (int k = 31; k >= 0; k--) begin
			c = q | (64'd1 << k);
			if (c * c <= t) q = c;
		end
		return clampw(longint'(q));
	endfunction

	function automatic longint sdot(longint ux, longint uy, longint uz,
			longint vx, longint vy, longint vz);
		return sadd(sadd(smul(ux, vx), smul(uy, vy)), smul(uz, vz));
	endfunction

	// picks the nearer non-negative distance; returns 0 none or a tie, 1 first, 2 second
	function automatic int choose(longint m0, longint m1);
		if (m0 >= 0 && (m0 < m1 || m1 < 0)) return 1;
		if (m1 >= 0 && (m1 < m0 || m0 < 0)) return 2;
		return 0;
	endfunction

	function automatic hit_t trace_ray(ray_t r);
		hit_t h;
		longint o[3], d[3], p[3], a[3], st[3], q[3];
		longint rad, hh, r2, aa, dp, ap, m, m0, m1;
		longint ad, ap2, app, fa, fpd, fpp, b, c, a2, disc, s, nb, r0, r1, axl;
		int sel;
		h = '{default: '0};
		o = '{r.ox, r.oy, r.oz};
		d = '{r.dx, r.dy, r.dz};
		for (int i = 0; i < 3; i++) begin
			a[i] = geo_a[i];
			p[i] = ssub(o[i], geo_c[i]);
		end
		rad = longint'(geo_dia) >>> 1;
		hh  = longint'(geo_hgt) >>> 1;
		r2  = smul(rad, rad);
		aa  = sdot(a[0], a[1], a[2], a[0], a[1], a[2]);
		if (aa != 0) begin
			ad  = sdot(a[0], a[1], a[2], d[0], d[1], d[2]);
			ap2 = sdot(a[0], a[1], a[2], p[0], p[1], p[2]);
			fa  = ssub(sdot(d[0], d[1], d[2], d[0], d[1], d[2]), sdiv(smul(ad, ad), aa));
			fpd = ssub(sdot(p[0], p[1], p[2], d[0], d[1], d[2]), sdiv(smul(ap2, ad), aa));
			fpp = ssub(sdot(p[0], p[1], p[2], p[0], p[1], p[2]), sdiv(smul(ap2, ap2), aa));
			b = sadd(fpd, fpd);
			c = ssub(fpp, r2);
			if (fa != 0) begin
				a2   = sadd(fa, fa);
				disc = ssub(smul(b, b), smul(sadd(a2, a2), c));
				if (disc >= 0) begin
					s  = ssqrt(disc);
					nb = sneg(b);
					r0 = sdiv(ssub(nb, s), a2);
					r1 = sdiv(sadd(nb, s), a2);
					sel = choose(r0, r1);
					if (!((r0 < 0 && r1 > 0) || (r1 < 0 && r0 > 0)) && sel != 0) begin
						m = sel == 1 ? r0 : r1;
						for (int i = 0; i < 3; i++) st[i] = smul(d[i], m);
						axl = sdot(a[0], a[1], a[2], sadd(p[0], st[0]),
							sadd(p[1], st[1]), sadd(p[2], st[2]));
						if (axl < 0) axl = sneg(axl);
						if (axl <= hh) begin
							h.wh = 1'b1;
							h.wx = word_t'(sadd(o[0], st[0]));
							h.wy = word_t'(sadd(o[1], st[1]));
							h.wz = word_t'(sadd(o[2], st[2]));
						end
					end
				end
			end
		end
		dp = sdot(a[0], a[1], a[2], d[0], d[1], d[2]);
		if (dp != 0) begin
			ap = sdot(a[0], a[1], a[2], p[0], p[1], p[2]);
			m0 = sdiv(ssub(hh, ap), dp);
			m1 = sdiv(ssub(-hh, ap), dp);
			sel = choose(m0, m1);
			if (sel != 0) begin
				m = sel == 1 ? m0 : m1;
				for (int i = 0; i < 3; i++) begin
					st[i] = smul(d[i], m);
					q[i]  = sadd(p[i], st[i]);
				end
				app = sdot(a[0], a[1], a[2], q[0], q[1], q[2]);
				if (ssub(sdot(q[0], q[1], q[2], q[0], q[1], q[2]), smul(app, app)) < r2) begin
					h.lh = 1'b1;
					h.lt = sel == 1;
					h.lx = word_t'(sadd(st[0], o[0]));
					h.ly = word_t'(sadd(st[1], o[1]));
					h.lz = word_t'(sadd(st[2], o[2]));
				end
			end
		end
		return h;
	endfunction

	// ---------------- driving ----------------
	function automatic bit idle_now();
		return !no_idle && $urandom_range(99) < 26;
	endfunction

	task automatic write_reg(cfg_reg_e idx, logic [W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx < REG_DIAMETER)
			case (idx)
				REG_CENTER_X: geo_c[0] = val;
				REG_CENTER_Y: geo_c[1] = val;
				REG_CENTER_Z: geo_c[2] = val;
				REG_AXIS_X:   geo_a[0] = val;
				REG_AXIS_Y:   geo_a[1] = val;
				default:      geo_a[2] = val;
			endcase
		else if (idx == REG_DIAMETER)
			geo_dia = val[W-2:0];
		else
			geo_hgt = val[W-2:0];
	endtask

	// drain before a geometry change: drop in_valid, wait for every expected result, then pause
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// send one ray; expectation queued when taken, valid left high, dropped by drain or an idle gap
	task automatic send_ray(ray_t r, bit fixed, hit_t h);
		if (idle_now()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (idle_now());
		end
		in_valid <= 1'b1;
		{org_x, org_y, org_z} <= {r.ox, r.oy, r.oz};
		{dir_x, dir_y, dir_z} <= {r.dx, r.dy, r.dz};
		do @(posedge clk); while (!in_ready);
		expected_hits.push_back(fixed ? h : trace_ray(r));
	endtask

	function automatic word_t rnd_word();
		case ($urandom_range(5))
			0: return word_t'($urandom());
			1: return WMAX;
			2: return WMIN;
			default: return word_t'($signed($urandom_range(8 * ONE)) - 4 * ONE);
		endcase
	endfunction

	// mostly rays aimed near the cylinder, unit-ish directions
	function automatic ray_t rnd_ray();
		ray_t r;
		word_t ax[3];
		if ($urandom_range(9) < 2)
			return '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word()};
		for (int i = 0; i < 3; i++)
			ax[i] = word_t'($signed($urandom_range(2 * ONE)) - ONE);
		r.ox = geo_c[0] + word_t'($signed($urandom_range(6 * ONE)) - 3 * ONE);
		r.oy = geo_c[1] + word_t'($signed($urandom_range(6 * ONE)) - 3 * ONE);
		r.oz = geo_c[2] + word_t'($signed($urandom_range(6 * ONE)) - 3 * ONE);
		// roughly toward the centre
		r.dx = (geo_c[0] - r.ox + ax[0]) >>> 1;
		r.dy = (geo_c[1] - r.oy + ax[1]) >>> 1;
		r.dz = (geo_c[2] - r.oz + ax[2]) >>> 1;
		return r;
	endfunction

	// ---------------- main sequence ----------------
	initial begin
		row_t rows[$];
		hit_t miss;
		logic [W-1:0] v;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_data  = '0;
		in_valid  = 1'b0;
		{org_x, org_y, org_z, dir_x, dir_y, dir_z} = '0;
		no_idle   = 1'b0;
		hold_off  = 1'b0;
		mismatches = 0;
		geo_c = '{0, 0, 0};
		geo_a = '{0, ONE, 0};
		geo_dia = ONE[W-2:0];
		geo_hgt = ONE[W-2:0];
		miss = '{default: '0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: unit cylinder on +y
		rows.push_back('{'{-2 * ONE, 0, 0, ONE, 0, 0}, 1'b0, miss});
		rows.push_back('{'{0, -2 * ONE, 0, 0, ONE, 0}, 1'b0, miss});
		// parallel to lids and outside: wall only, lid miss
		rows.push_back('{'{0, 0, -2 * ONE, 0, 0, ONE}, 1'b0, miss});
		// zero direction: degenerate quadratic and parallel lids
		rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, miss});
		// pointing away from the cylinder far out
		rows.push_back('{'{10 * ONE, 0, 0, ONE, 0, 0}, 1'b1, miss});
		// inside the cylinder: roots of opposite sign
		rows.push_back('{'{0, 0, 0, ONE, 0, 0}, 1'b0, miss});
		rows.push_back('{'{0, 0, 0, 0, -ONE, 0}, 1'b0, miss});
		// tangent ray: equal roots
		rows.push_back('{'{-2 * ONE, 0, ONE / 2, ONE, 0, 0}, 1'b0, miss});
		// above the top, going down / up
		rows.push_back('{'{ONE / 4, 3 * ONE, 0, 0, -ONE, 0}, 1'b0, miss});
		rows.push_back('{'{ONE / 4, 3 * ONE, 0, 0, ONE, 0}, 1'b0, miss});
		// saturating extremes
		rows.push_back('{'{WMAX, WMAX, WMAX, WMAX, WMAX, WMAX}, 1'b0, miss});
		rows.push_back('{'{WMIN, WMIN, WMIN, WMIN, WMIN, WMIN}, 1'b0, miss});
		rows.push_back('{'{WMIN, WMAX, WMIN, WMAX, WMIN, WMAX}, 1'b0, miss});
		rows.push_back('{'{-1, -1, -1, -1, -1, -1}, 1'b0, miss});
		foreach (rows[i]) send_ray(rows[i].r, rows[i].fixed, rows[i].h);
		drain();

		// zero axis: wall and lid both miss
		write_reg(REG_AXIS_Y, '0);
		send_ray('{-2 * ONE, 0, 0, ONE, 0, 0}, 1'b1, miss);
		send_ray('{0, 0, 0, 0, ONE, 0}, 1'b1, miss);
		drain();

		// extremes of every register
		write_reg(REG_CENTER_X, 32'h7fffffff);
		write_reg(REG_CENTER_Y, 32'h80000000);
		write_reg(REG_CENTER_Z, 32'hffffffff);
		write_reg(REG_AXIS_X, 32'h80000000);
		write_reg(REG_AXIS_Y, 32'h7fffffff);
		write_reg(REG_AXIS_Z, 32'hffffffff);
		write_reg(REG_DIAMETER, 32'hffffffff);
		write_reg(REG_HEIGHT, 32'h0);
		for (int i = 0; i < 8; i++) send_ray(rnd_ray(), 1'b0, miss);
		drain();
		write_reg(REG_DIAMETER, 32'h0);
		write_reg(REG_HEIGHT, 32'h7fffffff);
		for (int i = 0; i < 6; i++) send_ray(rnd_ray(), 1'b0, miss);
		drain();

		// random phases over several geometries
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_CENTER_X, $urandom_range(4 * ONE) - 2 * ONE);
			write_reg(REG_CENTER_Y, $urandom_range(4 * ONE) - 2 * ONE);
			write_reg(REG_CENTER_Z, $urandom_range(4 * ONE) - 2 * ONE);
			v = ph % 3 == 0 ? ONE : 0;
			write_reg(REG_AXIS_X, ph < 4 ? v : $urandom());
			write_reg(REG_AXIS_Y, ph % 3 == 1 ? ONE : (ph < 4 ? 0 : $urandom()));
			write_reg(REG_AXIS_Z, ph % 3 == 2 ? -ONE : (ph < 4 ? 0 : $urandom()));
			write_reg(REG_DIAMETER, $urandom_range(6 * ONE, ONE / 4));
			write_reg(REG_HEIGHT, $urandom_range(6 * ONE, ONE / 4));
			no_idle  = ph == 2;
			hold_off = ph == 3;
			for (int i = 0; i < N_RANDOM / 6; i++) send_ray(rnd_ray(), 1'b0, miss);
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// ---------------- receiver ----------------
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				// long hold-off so the pipeline fills and in_ready drops
				out_ready <= 1'b0;
				for (stall = 0; stall < 200; stall++) @(posedge clk);
				hold_off = 1'b0;
			end
			out_ready <= !idle_now();
		end
	end

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		hit_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{wall_hit, wall_x, wall_y, wall_z, lid_hit, lid_top, lid_x, lid_y, lid_z};
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word at cycle %0d", cycles);
			end else begin
				want = expected_hits.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp %p got %p", want, got);
				end
			end
		end
	end

endmodule
